// ----- rtl/chtea_pkg.sv -----
`timescale 1ns / 1ps

package chtea_pkg;

	localparam int CELL_W   = 16;
	localparam int ENERGY_W = 24;
	localparam int TIME_W   = 24;
	localparam int TRACK_W  = 20;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 5;

	// input action codes
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic                action;
		logic [CELL_W-1:0]   hit_cell;
		logic [ENERGY_W-1:0] deposit_energy;
		logic [TIME_W-1:0]   point_time;
		logic [TRACK_W-1:0]  track_id;
		logic                has_track;
	} hit_t;

	typedef struct packed {
		logic               accepted;
		logic [SUM_W-1:0]   total_energy;
		logic [TIME_W-1:0]  lead_time;
		logic [COUNT_W-1:0] track_count;
		logic [SUM_W-1:0]   track_energy;
		logic               table_full;
	} res_t;

	// one table entry
	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic [SUM_W-1:0]   energy;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_UPD,
		S_DONE
	} state_t;

	// saturating unsigned add
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

// ----- rtl/chtea_hit_if.sv -----
`timescale 1ns / 1ps

interface chtea_hit_if;
	import chtea_pkg::*;

	logic valid;
	logic ready;
	hit_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/chtea_res_if.sv -----
`timescale 1ns / 1ps

interface chtea_res_if;
	import chtea_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/chtea_cfg_if.sv -----
`timescale 1ns / 1ps

interface chtea_cfg_if;
	import chtea_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/chtea_mem.sv -----
`timescale 1ns / 1ps

module chtea_mem #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  chtea_pkg::entry_t   wdata,
	input  logic [IDX_W-1:0]    raddr,
	output chtea_pkg::entry_t   rdata
);
	import chtea_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- rtl/chtea_engine.sv -----
`timescale 1ns / 1ps

module chtea_engine #(
	parameter int MAX_TRACKS = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [chtea_pkg::CELL_W-1:0] tower_id,
	chtea_hit_if.sink                    hit_in,
	output logic                         res_valid,
	output chtea_pkg::res_t              res_data,
	input  logic                         res_ready
);
	import chtea_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS);

	state_t             state_q, state_d;
	hit_t               hit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TIME_W-1:0]  time_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   scan_q;
	logic               chk_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [SUM_W-1:0]   trk_e_q;
	logic               found_q;
	res_t               res_q;

	logic               accept;
	logic               issue;
	logic               match;
	logic               take;
	logic [SUM_W-1:0]   energy;
	logic [SUM_W-1:0]   sum_n;
	logic [SUM_W-1:0]   trk_sum;
	logic [CNT_W-1:0]   used_n;
	logic               append;
	logic               full;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	entry_t             mem_rdata;

	// track table
	chtea_mem #(
		.DEPTH (MAX_TRACKS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	assign hit_in.ready = (state_q == S_IDLE);
	assign accept       = hit_in.valid && hit_in.ready;
	assign take         = (hit_in.data.hit_cell == tower_id) &&
		(hit_in.data.deposit_energy != '0);

	// search: one read issued per cycle, previous read compared
	assign issue = (scan_q != used_q);
	assign match = chk_q && (mem_rdata.track == hit_q.track_id);

	// update datapath
	assign energy  = SUM_W'(hit_q.deposit_energy);
	assign sum_n   = sat_add(sum_q, energy);
	assign trk_sum = sat_add(trk_e_q, energy);
	assign append  = hit_q.has_track && !found_q && (used_q != CNT_MAX);
	assign full    = hit_q.has_track && !found_q && (used_q == CNT_MAX);
	assign used_n  = append ? used_q + CNT_W'(1) : used_q;

	assign mem_we    = (state_q == S_UPD) && hit_q.has_track && (found_q || append);
	assign mem_waddr = found_q ? hit_idx_q : used_q[IDX_W-1:0];
	assign mem_wdata = '{track: hit_q.track_id, energy: found_q ? trk_sum : energy};

	assign res_valid = (state_q == S_DONE);
	assign res_data  = res_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (hit_in.data.action == ACT_CLEAR || !take) begin
						state_d = S_DONE;
					end else if (!hit_in.data.has_track || used_q == '0) begin
						state_d = S_UPD;
					end else begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (match || !issue) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			time_q <= '0;
			used_q <= '0;
		end else if (accept && hit_in.data.action == ACT_CLEAR) begin
			sum_q  <= '0;
			time_q <= '0;
			used_q <= '0;
		end else if (state_q == S_UPD) begin
			sum_q  <= sum_n;
			used_q <= used_n;
			if (energy > sum_q) begin
				time_q <= hit_q.point_time;
			end
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			chk_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (accept) begin
			scan_q  <= '0;
			chk_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (state_q == S_SRCH) begin
			chk_q  <= issue;
			scan_q <= issue ? scan_q + CNT_W'(1) : scan_q;
			if (match) begin
				found_q <= 1'b1;
			end
		end
	end

	// item and hit entry payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q <= hit_in.data;
		end
		if (state_q == S_SRCH && match) begin
			hit_idx_q <= IDX_W'(scan_q - CNT_W'(1));
			trk_e_q   <= mem_rdata.energy;
		end
	end

	// result
	always_ff @(posedge clk) begin
		if (accept) begin
			if (hit_in.data.action == ACT_CLEAR) begin
				res_q <= '0;
			end else begin
				res_q <= '{accepted: 1'b0, total_energy: sum_q, lead_time: time_q,
					track_count: COUNT_W'(used_q), track_energy: '0, table_full: 1'b0};
			end
		end else if (state_q == S_UPD) begin
			res_q.accepted     <= 1'b1;
			res_q.total_energy <= sum_n;
			res_q.lead_time    <= (energy > sum_q) ? hit_q.point_time : time_q;
			res_q.track_count  <= COUNT_W'(used_n);
			res_q.table_full   <= full;
			if (!hit_q.has_track || full) begin
				res_q.track_energy <= '0;
			end else if (found_q) begin
				res_q.track_energy <= trk_sum;
			end else begin
				res_q.track_energy <= energy;
			end
		end
	end

endmodule

// ----- rtl/cell_hit_track_energy_accumulator.sv -----
`timescale 1ns / 1ps
// flow: a rejected or clear item goes from accept straight to its result, a point
// without track passes the update state, a point with track first scans the tracks
// held, one entry per cycle through the single read port of the track table; a new
// item is accepted only after the engine has handed on the result of the last one
// reset: cell total, time, track count, cell number and handshakes clear at once; table
// contents are left as they are and only entries below the track count are ever read

module cell_hit_track_energy_accumulator #(
	parameter int MAX_TRACKS = 16
) (
	input logic         clk,
	input logic         arst_n,
	chtea_cfg_if.sink   cfg,
	chtea_hit_if.sink   hit_in,
	chtea_res_if.source res_out
);
	import chtea_pkg::*;

	localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CNT_W = $clog2(MAX_TRACKS + 1);

	logic [CELL_W-1:0] tower_id_q;
	logic              res_valid;
	res_t              res_data;
	logic              res_ready;
	logic              out_valid_q;
	res_t              out_data_q;

	// cell number register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tower_id_q <= '0;
		end else if (cfg.valid) begin
			tower_id_q <= cfg.data;
		end
	end

	// accumulation engine
	chtea_engine #(
		.MAX_TRACKS (MAX_TRACKS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.tower_id  (tower_id_q),
		.hit_in    (hit_in),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	// output register, frees the engine while a result item waits
	assign res_ready = !out_valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_data_q;

endmodule
